[hw/rtl/tli_pkg.sv]
// Shared types and constants for the table linear interpolator.
package tli_pkg;

   // Opcodes of an input item.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_POINT_COUNT = 1'b0;
   localparam logic CSR_END_MODE    = 1'b1;

   // End modes.
   localparam logic [1:0] MODE_ZERO_EXTRAP = 2'd0;
   localparam logic [1:0] MODE_CLAMP       = 2'd1;

   // Result status codes.
   localparam logic [1:0] STATUS_INSIDE    = 2'd0;
   localparam logic [1:0] STATUS_BELOW     = 2'd1;
   localparam logic [1:0] STATUS_ABOVE     = 2'd2;
   localparam logic [1:0] STATUS_SATURATED = 2'd3;

   // Classified item as it travels through the queue.
   typedef struct packed {
      logic              is_query;
      logic [7:0]        index;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } item_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic [8:0] point_count;
      logic [1:0] end_mode;
   } cfg_type;

   // Queue status toward the front end and the top level.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SEARCH,
      S_CMP,
      S_LOAD_LO,
      S_LOAD_HI,
      S_ABS,
      S_MUL,
      S_DIV,
      S_SUM
   } state_type;

endpackage

[hw/rtl/tli_front.sv]
// Front end: accepts items, classifies them and pushes the ones with work into the queue.
module tli_front #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                     start,
   input  logic                     req_opcode,
   input  logic [7:0]               req_entry_index,
   input  logic signed [31:0]       req_entry_x,
   input  logic signed [31:0]       req_entry_y,
   input  logic signed [31:0]       req_query_x,
   input  tli_pkg::queue_status_type q_status,
   output logic                     busy,
   output logic                     push,
   output tli_pkg::item_type        push_item
);

   logic accept;
   logic is_query;
   logic slot_ok;

   // The front end stalls only while the queue is full.
   assign busy   = q_status.full;
   assign accept = start && !busy;

   // A write beyond the table does nothing, so it never enters the queue.
   assign is_query = (req_opcode == tli_pkg::OP_QUERY);
   assign slot_ok  = (32'(req_entry_index) < TABLE_DEPTH);
   assign push     = accept && (is_query || slot_ok);

   // A query carries its position in the x field.
   always_comb begin
      push_item.is_query = is_query;
      push_item.index    = req_entry_index;
      push_item.x        = is_query ? req_query_x : req_entry_x;
      push_item.y        = req_entry_y;
   end

endmodule

[hw/rtl/tli_queue.sv]
// Two-entry queue between the front end and the back end.
module tli_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tli_pkg::item_type         push_item,
   input  logic                      pop,
   output tli_pkg::item_type         head_item,
   output tli_pkg::queue_status_type status
);

   tli_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

[hw/rtl/tli_back.sv]
// Back end: table memory, binary search sequencer, interpolation and serial divider.
module tli_back #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tli_pkg::cfg_type         cfg,
   input  tli_pkg::item_type        head_item,
   input  logic                     q_empty,
   output logic                     pop,
   output logic                     rsp_strobe,
   output logic signed [31:0]       rsp_value,
   output logic [7:0]               rsp_segment,
   output logic [1:0]               rsp_status
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW = AW + 1;

   // Table memory with registered read data.
   logic signed [31:0] mem_x [TABLE_DEPTH];
   logic signed [31:0] mem_y [TABLE_DEPTH];
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic               mem_we, rd_en;
   logic [AW-1:0]      rd_addr;

   tli_pkg::state_type state_ff, state_in;

   logic signed [31:0] q_ff, q_in;
   logic signed [31:0] x0_ff, x0_in;
   logic signed [31:0] y0_ff, y0_in;
   logic [AW-1:0]      seg_ff, seg_in;
   logic [AW-1:0]      lo_ff, lo_in;
   logic [AW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      mid_ff, mid_in;
   logic [1:0]         base_status_ff, base_status_in;
   logic signed [32:0] dx_ff, dx_in;
   logic signed [32:0] dy_ff, dy_in;
   logic signed [32:0] dq_ff, dq_in;
   logic [31:0]        mdx_ff, mdx_in;
   logic [31:0]        mdy_ff, mdy_in;
   logic [31:0]        mdq_ff, mdq_in;
   logic               neg_ff, neg_in;
   logic               dx_zero_ff, dx_zero_in;
   logic [31:0]        rem_ff, rem_in;
   logic [63:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               strobe_in;
   logic signed [31:0] value_ff, value_in;
   logic [AW-1:0]      segment_ff, segment_in;
   logic [1:0]         status_ff, status_in;

   logic [NW-1:0]      n_eff;
   logic [AW-1:0]      last_idx;
   logic [AW-1:0]      pen_idx;
   logic [AW-1:0]      mid_calc;
   logic [AW-1:0]      span;
   logic [32:0]        rem_sh;
   logic               rem_ge;
   logic               quo_big;
   logic signed [42:0] sum;
   logic               zero_outside;

   // Effective point count, clamped to two and to the table depth.
   always_comb begin
      if (cfg.point_count < 9'd2) begin
         n_eff = NW'(2);
      end else if (32'(cfg.point_count) > TABLE_DEPTH) begin
         n_eff = NW'(TABLE_DEPTH);
      end else begin
         n_eff = NW'(cfg.point_count);
      end
   end

   assign last_idx     = AW'(n_eff - NW'(1));
   assign pen_idx      = AW'(n_eff - NW'(2));
   assign mid_calc     = AW'((NW'(lo_ff) + NW'(hi_ff)) >> 1);
   assign span         = hi_ff - lo_ff;
   assign zero_outside = (cfg.end_mode != tli_pkg::MODE_ZERO_EXTRAP) &&
                         (cfg.end_mode != tli_pkg::MODE_CLAMP);

   // One restoring division step.
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign rem_ge = (rem_sh >= {1'b0, mdx_ff});

   // Final sum and overflow test.
   assign quo_big = (|quo_ff[63:41]) || (quo_ff[40] && (|quo_ff[39:0]));
   assign sum     = neg_ff ? (43'(y0_ff) - $signed({2'b00, quo_ff[40:0]}))
                           : (43'(y0_ff) + $signed({2'b00, quo_ff[40:0]}));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tli_pkg::S_IDLE: begin
            if (!q_empty && head_item.is_query) begin
               state_in = tli_pkg::S_FIRST;
            end
         end
         tli_pkg::S_FIRST: begin
            if (q_ff < rd_x_ff) begin
               state_in = tli_pkg::S_IDLE;
            end else begin
               state_in = tli_pkg::S_LAST;
            end
         end
         tli_pkg::S_LAST: begin
            if (q_ff >= rd_x_ff) begin
               if ((cfg.end_mode == tli_pkg::MODE_CLAMP) ||
                   (zero_outside && (q_ff > rd_x_ff))) begin
                  state_in = tli_pkg::S_IDLE;
               end else begin
                  state_in = tli_pkg::S_LOAD_LO;
               end
            end else begin
               state_in = tli_pkg::S_SEARCH;
            end
         end
         tli_pkg::S_SEARCH: begin
            state_in = (span > AW'(1)) ? tli_pkg::S_CMP : tli_pkg::S_LOAD_LO;
         end
         tli_pkg::S_CMP:     state_in = tli_pkg::S_SEARCH;
         tli_pkg::S_LOAD_LO: state_in = tli_pkg::S_LOAD_HI;
         tli_pkg::S_LOAD_HI: state_in = tli_pkg::S_ABS;
         tli_pkg::S_ABS:     state_in = tli_pkg::S_MUL;
         tli_pkg::S_MUL: begin
            state_in = dx_zero_ff ? tli_pkg::S_IDLE : tli_pkg::S_DIV;
         end
         tli_pkg::S_DIV: begin
            if (cnt_ff == 6'd63) begin
               state_in = tli_pkg::S_SUM;
            end
         end
         tli_pkg::S_SUM:     state_in = tli_pkg::S_IDLE;
         default:            state_in = tli_pkg::S_IDLE;
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      pop            = 1'b0;
      mem_we         = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      q_in           = q_ff;
      x0_in          = x0_ff;
      y0_in          = y0_ff;
      seg_in         = seg_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      base_status_in = base_status_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      dq_in          = dq_ff;
      mdx_in         = mdx_ff;
      mdy_in         = mdy_ff;
      mdq_in         = mdq_ff;
      neg_in         = neg_ff;
      dx_zero_in     = dx_zero_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      strobe_in      = 1'b0;
      value_in       = value_ff;
      segment_in     = segment_ff;
      status_in      = status_ff;
      unique case (state_ff)
         tli_pkg::S_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               if (head_item.is_query) begin
                  q_in    = head_item.x;
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         tli_pkg::S_FIRST: begin
            if (q_ff < rd_x_ff) begin
               strobe_in  = 1'b1;
               value_in   = (cfg.end_mode == tli_pkg::MODE_CLAMP) ? rd_y_ff : '0;
               segment_in = '0;
               status_in  = tli_pkg::STATUS_BELOW;
            end else begin
               rd_en   = 1'b1;
               rd_addr = last_idx;
            end
         end
         tli_pkg::S_LAST: begin
            if (q_ff >= rd_x_ff) begin
               seg_in         = pen_idx;
               base_status_in = tli_pkg::STATUS_ABOVE;
               segment_in     = pen_idx;
               status_in      = tli_pkg::STATUS_ABOVE;
               if (cfg.end_mode == tli_pkg::MODE_CLAMP) begin
                  strobe_in = 1'b1;
                  value_in  = rd_y_ff;
               end else if (zero_outside && (q_ff > rd_x_ff)) begin
                  strobe_in = 1'b1;
                  value_in  = '0;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pen_idx;
               end
            end else begin
               lo_in          = '0;
               hi_in          = last_idx;
               base_status_in = tli_pkg::STATUS_INSIDE;
            end
         end
         tli_pkg::S_SEARCH: begin
            rd_en = 1'b1;
            if (span > AW'(1)) begin
               mid_in  = mid_calc;
               rd_addr = mid_calc;
            end else begin
               seg_in  = lo_ff;
               rd_addr = lo_ff;
            end
         end
         tli_pkg::S_CMP: begin
            if (rd_x_ff <= q_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
         end
         tli_pkg::S_LOAD_LO: begin
            x0_in   = rd_x_ff;
            y0_in   = rd_y_ff;
            dq_in   = 33'(q_ff) - 33'(rd_x_ff);
            rd_en   = 1'b1;
            rd_addr = AW'(seg_ff + AW'(1));
         end
         tli_pkg::S_LOAD_HI: begin
            dx_in = 33'(rd_x_ff) - 33'(x0_ff);
            dy_in = 33'(rd_y_ff) - 33'(y0_ff);
         end
         tli_pkg::S_ABS: begin
            mdx_in     = 32'(dx_ff[32] ? -dx_ff : dx_ff);
            mdy_in     = 32'(dy_ff[32] ? -dy_ff : dy_ff);
            mdq_in     = 32'(dq_ff[32] ? -dq_ff : dq_ff);
            neg_in     = dy_ff[32] ^ dq_ff[32] ^ dx_ff[32];
            dx_zero_in = (dx_ff == '0);
         end
         tli_pkg::S_MUL: begin
            quo_in = 64'(mdy_ff) * 64'(mdq_ff);
            rem_in = '0;
            cnt_in = '0;
            if (dx_zero_ff) begin
               strobe_in  = 1'b1;
               value_in   = y0_ff;
               segment_in = seg_ff;
               status_in  = base_status_ff;
            end
         end
         tli_pkg::S_DIV: begin
            rem_in = rem_ge ? 32'(rem_sh - {1'b0, mdx_ff}) : rem_sh[31:0];
            quo_in = {quo_ff[62:0], rem_ge};
            cnt_in = cnt_ff + 6'd1;
         end
         tli_pkg::S_SUM: begin
            strobe_in  = 1'b1;
            segment_in = seg_ff;
            if (quo_big) begin
               value_in  = neg_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
               status_in = tli_pkg::STATUS_SATURATED;
            end else if (sum[42:31] != {12{sum[42]}}) begin
               value_in  = sum[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
               status_in = tli_pkg::STATUS_SATURATED;
            end else begin
               value_in  = sum[31:0];
               status_in = base_status_ff;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Table memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[AW'(head_item.index)] <= head_item.x;
         mem_y[AW'(head_item.index)] <= head_item.y;
      end
      if (rd_en) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tli_pkg::S_IDLE;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      q_ff           <= q_in;
      x0_ff          <= x0_in;
      y0_ff          <= y0_in;
      seg_ff         <= seg_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      base_status_ff <= base_status_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      dq_ff          <= dq_in;
      mdx_ff         <= mdx_in;
      mdy_ff         <= mdy_in;
      mdq_ff         <= mdq_in;
      neg_ff         <= neg_in;
      dx_zero_ff     <= dx_zero_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      value_ff       <= value_in;
      segment_ff     <= segment_in;
      status_ff      <= status_in;
   end

   assign rsp_value   = value_ff;
   assign rsp_segment = 8'(segment_ff);
   assign rsp_status  = status_ff;

endmodule

[hw/rtl/table_linear_interpolator.sv]
// Top level of the table linear interpolator: configuration registers and module wiring.
//
// Channel   Direction  Handshake                 Payload
// req_      in         start high, busy low      opcode, entry_index, entry_x, entry_y, query_x
// rsp_      out        rsp_strobe, one cycle     value, segment, status
// csr_      in         csr_we                    csr_index, csr_wdata
//
// The back end takes a write item in its idle state. A query reads the table memory once per
// search step and, when it interpolates on a segment of nonzero width, runs a 64-step serial
// divider for the interpolation quotient; it is done before the next item leaves the queue.
// Reset is synchronous and empties the queue and the sequencer; table contents stay
// undefined until written. Two items can wait in the queue; busy is high while it is full.
// The result receiver cannot stall; each result is shown for exactly one cycle.
module table_linear_interpolator #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [7:0]         req_entry_index,
   input  logic signed [31:0] req_entry_x,
   input  logic signed [31:0] req_entry_y,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_value,
   output logic [7:0]         rsp_segment,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [8:0]         csr_wdata
);

   logic [8:0] point_count_ff;
   logic [1:0] end_mode_ff;

   tli_pkg::cfg_type          cfg;
   tli_pkg::queue_status_type q_status;
   tli_pkg::item_type         push_item;
   tli_pkg::item_type         head_item;
   logic                      push;
   logic                      pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 9'd2;
         end_mode_ff    <= 2'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            tli_pkg::CSR_POINT_COUNT: point_count_ff <= csr_wdata;
            tli_pkg::CSR_END_MODE:    end_mode_ff    <= csr_wdata[1:0];
            default:                  end_mode_ff    <= end_mode_ff;
         endcase
      end
   end

   assign cfg.point_count = point_count_ff;
   assign cfg.end_mode    = end_mode_ff;

   tli_front #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_front (
      .start           (start),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .q_status        (q_status),
      .busy            (busy),
      .push            (push),
      .push_item       (push_item)
   );

   tli_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   tli_back #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head_item   (head_item),
      .q_empty     (q_status.empty),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_value   (rsp_value),
      .rsp_segment (rsp_segment),
      .rsp_status  (rsp_status)
   );

`ifndef SYNTHESIS
   // Reset leaves the queue empty and no result pending.
   a_reset_clean: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("queue or result not cleared by reset");

   // Every query passes through idle, so results never come in adjacent cycles.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in adjacent cycles");

   // The queue cannot be full and empty at once.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty together");

   // A query below the table always reports the first segment.
   a_below_seg: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == tli_pkg::STATUS_BELOW)) |-> (rsp_segment == 8'd0))
      else $error("below-table result with nonzero segment");
`endif

endmodule

[tb/sv/table_linear_interpolator_checker.sv]
// Checker for the table linear interpolator: predicts each query result and compares it.
module table_linear_interpolator_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_opcode,
   input  logic [7:0]         req_entry_index,
   input  logic signed [31:0] req_entry_x,
   input  logic signed [31:0] req_entry_y,
   input  logic signed [31:0] req_query_x,
   input  logic               rsp_strobe,
   input  logic signed [31:0] rsp_value,
   input  logic [7:0]         rsp_segment,
   input  logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [8:0]         csr_wdata,
   output int                 pending,
   output int                 errors
);

   localparam int DEPTH = 256;

   typedef struct packed {
      logic signed [31:0] value;
      logic [7:0]         segment;
      logic [1:0]         status;
   } lookup_result_type;

   // Shadow copy of the breakpoint table and the configuration.
   logic signed [31:0] abscissa_copy [DEPTH];
   logic signed [31:0] ordinate_copy [DEPTH];
   logic [8:0]         count_reg;
   logic [1:0]         mode_reg;
   lookup_result_type  lookup_queue [$];

   // Linear interpolation on one segment, truncated toward zero and saturated.
   function automatic longint interpolate(longint x0, longint y0, longint x1, longint y1,
                                          longint q, output bit sat);
      longint      dx, dy, dq, sum;
      logic [63:0] adx, ady, adq, quo;
      bit          neg;
      dx  = x1 - x0;
      dy  = y1 - y0;
      dq  = q - x0;
      sat = 1'b0;
      if (dx == 0) begin
         return y0;
      end
      adx = 64'(dx < 0 ? -dx : dx);
      ady = 64'(dy < 0 ? -dy : dy);
      adq = 64'(dq < 0 ? -dq : dq);
      quo = (ady * adq) / adx;
      neg = ((dy < 0) != (dq < 0)) != (dx < 0);
      if (quo > (64'd1 << 40)) begin
         sat = 1'b1;
         return neg ? -64'sd2147483648 : 64'sd2147483647;
      end
      sum = neg ? y0 - longint'(quo) : y0 + longint'(quo);
      if (sum > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (sum < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return sum;
   endfunction

   // Expected result of one query at the current table and configuration.
   function automatic lookup_result_type lookup(logic signed [31:0] qx);
      int                n, lo, hi, mid, seg;
      longint            q, v;
      bit                sat;
      logic [1:0]        st;
      lookup_result_type r;
      n   = (count_reg < 2) ? 2 : ((count_reg > DEPTH) ? DEPTH : int'(count_reg));
      q   = qx;
      sat = 1'b0;
      if (q < abscissa_copy[0]) begin
         seg = 0;
         st  = tli_pkg::STATUS_BELOW;
         v   = (mode_reg == tli_pkg::MODE_CLAMP) ? longint'(ordinate_copy[0]) : 0;
      end else if (q >= abscissa_copy[n-1]) begin
         seg = n - 2;
         st  = tli_pkg::STATUS_ABOVE;
         if (mode_reg == tli_pkg::MODE_CLAMP) begin
            v = ordinate_copy[n-1];
         end else if (mode_reg != tli_pkg::MODE_ZERO_EXTRAP && q > abscissa_copy[n-1]) begin
            v = 0;
         end else begin
            v = interpolate(abscissa_copy[seg], ordinate_copy[seg], abscissa_copy[seg+1],
                            ordinate_copy[seg+1], q, sat);
         end
      end else begin
         lo = 0;
         hi = n - 1;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (abscissa_copy[mid] <= q) lo = mid;
            else hi = mid;
         end
         seg = lo;
         st  = tli_pkg::STATUS_INSIDE;
         v   = interpolate(abscissa_copy[seg], ordinate_copy[seg], abscissa_copy[seg+1],
                           ordinate_copy[seg+1], q, sat);
      end
      if (sat) st = tli_pkg::STATUS_SATURATED;
      r.value   = v[31:0];
      r.segment = seg[7:0];
      r.status  = st;
      return r;
   endfunction

   // Track accepted items, register writes and results on every rising edge.
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (reset) begin
         lookup_queue.delete();
         pending = 0;
         errors  = 0;
         count_reg <= 9'd2;
         mode_reg  <= tli_pkg::MODE_ZERO_EXTRAP;
      end else begin
         if (csr_we) begin
            if (csr_index == tli_pkg::CSR_POINT_COUNT) count_reg <= csr_wdata;
            else mode_reg <= csr_wdata[1:0];
         end
         if (start && !busy) begin
            if (req_opcode == tli_pkg::OP_WRITE) begin
               abscissa_copy[req_entry_index] = req_entry_x;
               ordinate_copy[req_entry_index] = req_entry_y;
            end else begin
               lookup_queue.push_back(lookup(req_query_x));
            end
         end
         if (rsp_strobe) begin
            if (lookup_queue.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("Unexpected result: value %h segment %0d status %0d",
                           rsp_value, rsp_segment, rsp_status);
            end else begin
               exp_r = lookup_queue.pop_front();
               if (exp_r.value !== rsp_value || exp_r.segment !== rsp_segment ||
                   exp_r.status !== rsp_status) begin
                  errors = errors + 1;
                  if (errors <= 10)
                     $display("Mismatch: expected value %h segment %0d status %0d, got %h %0d %0d",
                              exp_r.value, exp_r.segment, exp_r.status,
                              rsp_value, rsp_segment, rsp_status);
               end
            end
         end
         pending = lookup_queue.size();
      end
   end

endmodule

[tb/sv/table_linear_interpolator_test.sv]
// Top of the table linear interpolator testbench: clock, reset, stimulus and verdict.
module table_linear_interpolator_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_opcode = tli_pkg::OP_WRITE;
   logic [7:0]         req_entry_index = '0;
   logic signed [31:0] req_entry_x = '0;
   logic signed [31:0] req_entry_y = '0;
   logic signed [31:0] req_query_x = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_value;
   logic [7:0]         rsp_segment;
   logic [1:0]         rsp_status;
   logic               csr_we = 1'b0;
   logic               csr_index = tli_pkg::CSR_POINT_COUNT;
   logic [8:0]         csr_wdata = '0;
   int                 pending;
   int                 errors;

   int                 idle_pct = 0;
   int                 item_total = 0;
   int                 used_points = 2;
   logic signed [31:0] loaded_x [256];

   table_linear_interpolator u_dut (.*);

   table_linear_interpolator_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Present one item and hold it until the block accepts it.
   task automatic send_item(logic op, logic [7:0] idx, logic signed [31:0] ex,
                            logic signed [31:0] ey, logic signed [31:0] qx);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_entry_x     <= ex;
      req_entry_y     <= ey;
      req_query_x     <= qx;
      #1;
      while (busy) @(negedge clock);
      @(posedge clock);
      item_total++;
   endtask

   task automatic write_entry(int idx, logic signed [31:0] ex, logic signed [31:0] ey);
      send_item(tli_pkg::OP_WRITE, idx[7:0], ex, ey, $urandom);
      if (idx < 256) loaded_x[idx] = ex;
   endtask

   task automatic query(logic signed [31:0] qx);
      send_item(tli_pkg::OP_QUERY, 8'($urandom), $urandom, $urandom, qx);
   endtask

   // Wait until every expected result has come and the block has gone quiet.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_config(logic [8:0] count, logic [1:0] mode);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= tli_pkg::CSR_POINT_COUNT;
      csr_wdata <= count;
      @(negedge clock);
      csr_index <= tli_pkg::CSR_END_MODE;
      csr_wdata <= {7'd0, mode};
      @(negedge clock);
      csr_we    <= 1'b0;
      used_points = (count < 2) ? 2 : ((count > 256) ? 256 : int'(count));
   endtask

   // Load the points in use with a sorted, an unsorted or a wide-range table.
   task automatic load_table(int kind);
      longint acc, lim, step;
      int     y_small;
      logic signed [31:0] yv;
      y_small = $urandom_range(1);
      acc  = longint'($signed(32'($urandom))) >>> $urandom_range(0, 16);
      lim  = 64'sd2147483647;
      step = 64'sd1 << $urandom_range(0, 24);
      for (int i = 0; i < used_points; i++) begin
         yv = y_small ? $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20)
                      : $signed(32'($urandom));
         case (kind)
            0: begin
               write_entry(i, acc[31:0], yv);
               acc = acc + longint'($urandom_range(0, 3) == 0 ? 0 : $urandom % step);
               if (acc > lim) acc = lim;
            end
            1: write_entry(i, $urandom, yv);
            default: begin
               write_entry(i, acc[31:0], yv);
               acc = acc + (longint'($urandom) << $urandom_range(0, 1));
               if (acc > lim) acc = lim;
            end
         endcase
      end
   endtask

   // One query near the loaded breakpoints, at one exactly, or anywhere.
   task automatic random_query();
      int k;
      k = $urandom_range(0, used_points - 1);
      case ($urandom_range(0, 5))
         0: query(loaded_x[k]);
         1: query(loaded_x[k] + 1);
         2: query(loaded_x[k] - 1);
         3: query($urandom);
         default: query(loaded_x[k] + $signed(32'($urandom_range(0, 1 << 18))) - (1 << 17));
      endcase
   endtask

   initial begin
      logic [8:0] count;
      logic [1:0] mode;
      int         phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every slot gets a value first, so no query reads an unwritten entry.
      for (int i = 0; i < 256; i++) write_entry(i, $urandom, $urandom);
      drain();

      // Directed table with a zero-width segment and extreme ordinates.
      for (int m = 0; m < 4; m++) begin
         set_config(9'd4, m[1:0]);
         write_entry(0, -32'sh10000, 32'sh7fff0000);
         write_entry(1, 32'sh0, -32'sh80000000);
         write_entry(2, 32'sh0, 32'sh12345);
         write_entry(3, 32'sh2, 32'sh7fffffff);
         query(-32'sh80000000);
         query(-32'sh10000);
         query(-32'sh8000);
         query(32'sh0);
         query(32'sh1);
         query(32'sh2);
         query(32'sh7fffffff);
         drain();
      end

      // Random phases walking through counts, end modes and idling levels.
      phase = 0;
      while (item_total < 1350) begin
         case (phase)
            0: count = 9'd2;
            1: count = 9'd256;
            2: count = 9'd0;
            3: count = 9'd511;
            default: count = ($urandom_range(0, 9) == 0) ? 9'($urandom)
                                                          : 9'($urandom_range(2, 9));
         endcase
         mode = (phase < 4) ? phase[1:0] : 2'($urandom);
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 51;
            default: idle_pct = 12;
         endcase
         set_config(count, mode);
         load_table((phase % 5 == 4) ? 1 : $urandom_range(0, 2) * 2);
         repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 19) == 0)
               write_entry($urandom_range(0, used_points - 1), $urandom, $urandom);
            else
               random_query();
         end
         drain();
         phase++;
      end

      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #30000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
hw/rtl/tli_pkg.sv
hw/rtl/tli_front.sv
hw/rtl/tli_queue.sv
hw/rtl/tli_back.sv
hw/rtl/table_linear_interpolator.sv
tb/sv/table_linear_interpolator_checker.sv
tb/sv/table_linear_interpolator_test.sv
